### rtl/core/apor_pkg.sv
package apor_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int DATA_W      = 32;
   localparam int SAT_BITS    = (COORD_WIDTH < DATA_W) ? COORD_WIDTH : DATA_W;
   localparam int BOUND_W     = DATA_W + 1;
   localparam int DIFF_W      = DATA_W + 2;
   localparam int MAG_W       = DATA_W + 1;
   localparam int SUM_W       = DATA_W + 3;
   localparam int CSR_IDX_W   = 3;

   localparam logic signed [SUM_W-1:0] SAT_HI =
      SUM_W'((longint'(1) <<< (SAT_BITS - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

   localparam logic [1:0] AXIS_NONE = 2'd0;
   localparam logic [1:0] AXIS_X    = 2'd1;
   localparam logic [1:0] AXIS_Y    = 2'd2;
   localparam logic [1:0] AXIS_Z    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_OFF_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OFF_MAX_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFF_MIN_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OFF_MAX_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OFF_MIN_Z = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OFF_MAX_Z = 3'd5;

   localparam logic signed [DATA_W-1:0] OFF_MIN_RESET = -32'sd65536;
   localparam logic signed [DATA_W-1:0] OFF_MAX_RESET = 32'sd65536;

   typedef struct packed {
      logic                     pass_start;
      logic signed [DATA_W-1:0] start_pos_x;
      logic signed [DATA_W-1:0] start_pos_y;
      logic signed [DATA_W-1:0] start_pos_z;
      logic signed [DATA_W-1:0] other_min_x;
      logic signed [DATA_W-1:0] other_max_x;
      logic signed [DATA_W-1:0] other_min_y;
      logic signed [DATA_W-1:0] other_max_y;
      logic signed [DATA_W-1:0] other_min_z;
      logic signed [DATA_W-1:0] other_max_z;
   } req_payload_type;

   typedef struct packed {
      logic                     hit;
      logic [1:0]               push_axis;
      logic signed [DATA_W-1:0] push_amount;
      logic signed [DATA_W-1:0] new_pos_x;
      logic signed [DATA_W-1:0] new_pos_y;
      logic signed [DATA_W-1:0] new_pos_z;
   } rsp_payload_type;

   typedef struct packed {
      logic                     sep;
      logic signed [DIFF_W-1:0] push;
      logic [MAG_W-1:0]         push_mag;
   } axis_res_type;

   function automatic logic signed [DATA_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] c;
      if (v > SAT_HI) begin
         c = SAT_HI;
      end else if (v < SAT_LO) begin
         c = SAT_LO;
      end else begin
         c = v;
      end
      return c[DATA_W-1:0];
   endfunction

endpackage

### rtl/core/apor_axis.sv
module apor_axis
   import apor_pkg::*;
(
   input  logic signed [DATA_W-1:0] pos,
   input  logic signed [DATA_W-1:0] off_min,
   input  logic signed [DATA_W-1:0] off_max,
   input  logic signed [DATA_W-1:0] t_min,
   input  logic signed [DATA_W-1:0] t_max,
   output axis_res_type             res
);

   logic signed [BOUND_W-1:0] own_min;
   logic signed [BOUND_W-1:0] own_max;
   logic signed [BOUND_W-1:0] t_min_ext;
   logic signed [BOUND_W-1:0] t_max_ext;
   logic signed [DIFF_W-1:0]  diff_a;
   logic signed [DIFF_W-1:0]  diff_b;
   logic [MAG_W-1:0]          mag_a;
   logic [MAG_W-1:0]          mag_b;

   assign own_min   = {pos[DATA_W-1], pos} + {off_min[DATA_W-1], off_min};
   assign own_max   = {pos[DATA_W-1], pos} + {off_max[DATA_W-1], off_max};
   assign t_min_ext = {t_min[DATA_W-1], t_min};
   assign t_max_ext = {t_max[DATA_W-1], t_max};

   assign diff_a = {own_max[BOUND_W-1], own_max} - {t_min_ext[BOUND_W-1], t_min_ext};
   assign diff_b = {own_min[BOUND_W-1], own_min} - {t_max_ext[BOUND_W-1], t_max_ext};

   always_comb begin
      logic signed [DIFF_W-1:0] neg_a;
      logic signed [DIFF_W-1:0] neg_b;
      neg_a = -diff_a;
      neg_b = -diff_b;
      mag_a = diff_a[DIFF_W-1] ? neg_a[MAG_W-1:0] : diff_a[MAG_W-1:0];
      mag_b = diff_b[DIFF_W-1] ? neg_b[MAG_W-1:0] : diff_b[MAG_W-1:0];

      res.sep = ((own_max <= t_min_ext) && (own_min <= t_min_ext)) ||
                ((own_max >= t_max_ext) && (own_min >= t_max_ext));
      if (mag_a <= mag_b) begin
         res.push     = -$signed({1'b0, mag_a});
         res.push_mag = mag_a;
      end else begin
         res.push     = $signed({1'b0, mag_b});
         res.push_mag = mag_b;
      end
   end

endmodule

### rtl/core/aabb_push_out_resolver.sv
// channel | direction | handshake           | beat
// req_    | in        | req_valid/req_stall | one other box, optional start position
// rsp_    | out       | rsp_valid/rsp_stall | hit, push axis and amount, new position
// csr_    | in        | csr_valid/csr_ready | register index and write data
//
// One beat per cycle in, one beat per cycle out while rsp_stall holds no result.
// The rate is set by the position feedback: bounds, push, minimum and the
// position update all settle combinationally from the position registers.
// Reset clears the position to zero and loads the default offsets.
// req_stall rises only while a result beat is held by rsp_stall.
module aabb_push_out_resolver
   import apor_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_payload_type          req_data,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_payload_type          rsp_data,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic signed [DATA_W-1:0] csr_data
);

   logic signed [DATA_W-1:0] off_min_x_ff, off_max_x_ff;
   logic signed [DATA_W-1:0] off_min_y_ff, off_max_y_ff;
   logic signed [DATA_W-1:0] off_min_z_ff, off_max_z_ff;

   logic signed [DATA_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [DATA_W-1:0] pos_x_in, pos_y_in, pos_z_in;
   logic signed [DATA_W-1:0] cur_x, cur_y, cur_z;

   logic                     rsp_valid_ff;
   rsp_payload_type          rsp_data_ff;
   rsp_payload_type          rsp_data_in;

   logic                     req_accept;
   axis_res_type             res_x, res_y, res_z;

   assign csr_ready  = 1'b1;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      if (req_data.pass_start) begin
         cur_x = sat_coord({{(SUM_W-DATA_W){req_data.start_pos_x[DATA_W-1]}},
                            req_data.start_pos_x});
         cur_y = sat_coord({{(SUM_W-DATA_W){req_data.start_pos_y[DATA_W-1]}},
                            req_data.start_pos_y});
         cur_z = sat_coord({{(SUM_W-DATA_W){req_data.start_pos_z[DATA_W-1]}},
                            req_data.start_pos_z});
      end else begin
         cur_x = pos_x_ff;
         cur_y = pos_y_ff;
         cur_z = pos_z_ff;
      end
   end

   apor_axis u_axis_x (
      .pos     (cur_x),
      .off_min (off_min_x_ff),
      .off_max (off_max_x_ff),
      .t_min   (req_data.other_min_x),
      .t_max   (req_data.other_max_x),
      .res     (res_x)
   );

   apor_axis u_axis_y (
      .pos     (cur_y),
      .off_min (off_min_y_ff),
      .off_max (off_max_y_ff),
      .t_min   (req_data.other_min_y),
      .t_max   (req_data.other_max_y),
      .res     (res_y)
   );

   apor_axis u_axis_z (
      .pos     (cur_z),
      .off_min (off_min_z_ff),
      .off_max (off_max_z_ff),
      .t_min   (req_data.other_min_z),
      .t_max   (req_data.other_max_z),
      .res     (res_z)
   );

   always_comb begin
      logic                     hit;
      logic signed [DIFF_W-1:0] push;
      logic signed [DATA_W-1:0] cur;
      logic signed [DATA_W-1:0] moved;
      logic [1:0]               axis;

      hit  = !res_x.sep && !res_y.sep && !res_z.sep;
      axis = AXIS_NONE;
      push = '0;
      cur  = cur_x;
      if (hit) begin
         if ((res_x.push_mag < res_y.push_mag) && (res_x.push_mag < res_z.push_mag)) begin
            axis = AXIS_X;
            push = res_x.push;
            cur  = cur_x;
         end else if ((res_y.push_mag < res_x.push_mag) &&
                      (res_y.push_mag < res_z.push_mag)) begin
            axis = AXIS_Y;
            push = res_y.push;
            cur  = cur_y;
         end else if ((res_z.push_mag < res_x.push_mag) &&
                      (res_z.push_mag < res_y.push_mag)) begin
            axis = AXIS_Z;
            push = res_z.push;
            cur  = cur_z;
         end
      end

      moved = sat_coord({{(SUM_W-DATA_W){cur[DATA_W-1]}}, cur} +
                        {{(SUM_W-DIFF_W){push[DIFF_W-1]}}, push});

      pos_x_in = (axis == AXIS_X) ? moved : cur_x;
      pos_y_in = (axis == AXIS_Y) ? moved : cur_y;
      pos_z_in = (axis == AXIS_Z) ? moved : cur_z;

      rsp_data_in.hit         = hit;
      rsp_data_in.push_axis   = axis;
      rsp_data_in.push_amount = sat_coord({{(SUM_W-DIFF_W){push[DIFF_W-1]}}, push});
      rsp_data_in.new_pos_x   = pos_x_in;
      rsp_data_in.new_pos_y   = pos_y_in;
      rsp_data_in.new_pos_z   = pos_z_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_min_x_ff <= OFF_MIN_RESET;
         off_max_x_ff <= OFF_MAX_RESET;
         off_min_y_ff <= OFF_MIN_RESET;
         off_max_y_ff <= OFF_MAX_RESET;
         off_min_z_ff <= OFF_MIN_RESET;
         off_max_z_ff <= OFF_MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_OFF_MIN_X: off_min_x_ff <= csr_data;
            REG_OFF_MAX_X: off_max_x_ff <= csr_data;
            REG_OFF_MIN_Y: off_min_y_ff <= csr_data;
            REG_OFF_MAX_Y: off_max_y_ff <= csr_data;
            REG_OFF_MIN_Z: off_min_z_ff <= csr_data;
            REG_OFF_MAX_Z: off_max_z_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pos_z_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         pos_z_ff     <= pos_z_in;
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted beat produced no result");

   a_pos_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> ($stable(pos_x_ff) && $stable(pos_y_ff) && $stable(pos_z_ff)))
      else $error("position changed without an accepted beat");

   a_no_move_keeps_pos: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_data.pass_start) |=>
         ((rsp_data_ff.push_axis != AXIS_NONE) ||
          ((rsp_data_ff.new_pos_x == $past(pos_x_ff)) &&
           (rsp_data_ff.new_pos_y == $past(pos_y_ff)) &&
           (rsp_data_ff.new_pos_z == $past(pos_z_ff)))))
      else $error("position moved with no push axis");

   a_miss_no_push: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.hit) |->
         ((rsp_data_ff.push_axis == AXIS_NONE) && (rsp_data_ff.push_amount == '0)))
      else $error("push reported without a hit");

endmodule

### dv/aabb_push_out_resolver_tb.sv
`timescale 1ns / 1ps

module aabb_push_out_resolver_tb;
   import apor_pkg::*;

   localparam longint ONE         = 64'sd65536;
   localparam longint COORD_HI    = 64'sd2147483647;
   localparam longint COORD_LO    = -64'sd2147483648;
   localparam longint REACH_CAP   = 64'sd1073741824;
   localparam int     CYCLE_LIMIT = 400000;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_payload_type          req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_payload_type          rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic signed [DATA_W-1:0] csr_data  = '0;

   longint          ego_pos [3];
   longint          off_min [3];
   longint          off_max [3];
   rsp_payload_type pending_results [$];

   bit gaps_on      = 1'b0;
   bit stall_on     = 1'b0;
   int burst_left   = 0;
   int stall_run    = 0;
   int cycles       = 0;
   int boxes_sent   = 0;
   int beats_seen   = 0;
   int overlaps     = 0;
   int moves        = 0;
   int settings_run = 0;
   int mismatches   = 0;

   aabb_push_out_resolver dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles,
                  pending_results.size());
         $display("FAIL aabb_push_out_resolver");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else begin
         rsp_stall <= stall_on && ($urandom_range(0, 2) == 0);
         stall_run <= $urandom_range(0, 5);
      end
   end

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint clamp_coord(input longint v);
      if (v > COORD_HI) return COORD_HI;
      if (v < COORD_LO) return COORD_LO;
      return v;
   endfunction

   function automatic longint jitter(input longint reach);
      return longint'($urandom_range(0, 32'(2 * reach))) - reach;
   endfunction

   function automatic longint pick_coord();
      case ($urandom_range(0, 9))
         0: return COORD_LO;
         1: return COORD_HI;
         2, 3: return longint'($signed($urandom));
         default: return jitter(64 * ONE);
      endcase
   endfunction

   // advance the own position by one beat and form the result it causes
   function automatic rsp_payload_type resolve_box(input req_payload_type b);
      rsp_payload_type r;
      longint lo [3], hi [3], tlo [3], thi [3], push [3], size [3];
      longint a, c;
      int pick;
      if (b.pass_start) begin
         ego_pos[0] = longint'(b.start_pos_x);
         ego_pos[1] = longint'(b.start_pos_y);
         ego_pos[2] = longint'(b.start_pos_z);
      end
      tlo[0] = longint'(b.other_min_x); thi[0] = longint'(b.other_max_x);
      tlo[1] = longint'(b.other_min_y); thi[1] = longint'(b.other_max_y);
      tlo[2] = longint'(b.other_min_z); thi[2] = longint'(b.other_max_z);
      r = '0;
      r.hit = 1'b1;
      r.push_axis = AXIS_NONE;
      pick = -1;
      for (int k = 0; k < 3; k++) begin
         lo[k] = ego_pos[k] + off_min[k];
         hi[k] = ego_pos[k] + off_max[k];
         if ((hi[k] <= tlo[k] && lo[k] <= tlo[k]) || (hi[k] >= thi[k] && lo[k] >= thi[k]))
            r.hit = 1'b0;
         a = magnitude(hi[k] - tlo[k]);
         c = magnitude(lo[k] - thi[k]);
         push[k] = (a <= c) ? -a : c;
         size[k] = magnitude(push[k]);
      end
      if (r.hit) begin
         overlaps++;
         if (size[0] < size[1] && size[0] < size[2]) pick = 0;
         else if (size[1] < size[0] && size[1] < size[2]) pick = 1;
         else if (size[2] < size[0] && size[2] < size[1]) pick = 2;
      end
      if (pick >= 0) begin
         moves++;
         ego_pos[pick] = clamp_coord(ego_pos[pick] + push[pick]);
         r.push_amount = 32'(clamp_coord(push[pick]));
         r.push_axis = (pick == 0) ? AXIS_X : (pick == 1) ? AXIS_Y : AXIS_Z;
      end
      r.new_pos_x = 32'(ego_pos[0]);
      r.new_pos_y = 32'(ego_pos[1]);
      r.new_pos_z = 32'(ego_pos[2]);
      return r;
   endfunction

   function automatic req_payload_type box_of(input bit fresh,
         input longint sx, sy, sz, x0, x1, y0, y1, z0, z1);
      req_payload_type b;
      b.pass_start  = fresh;
      b.start_pos_x = 32'(sx);
      b.start_pos_y = 32'(sy);
      b.start_pos_z = 32'(sz);
      b.other_min_x = 32'(x0);
      b.other_max_x = 32'(x1);
      b.other_min_y = 32'(y0);
      b.other_max_y = 32'(y1);
      b.other_min_z = 32'(z0);
      b.other_max_z = 32'(z1);
      return b;
   endfunction

   // place the other box around where the own box is, or will be on a fresh pass
   function automatic req_payload_type box_around(input bit fresh, input longint sx, sy, sz);
      longint base [3], tlo [3], thi [3];
      longint centre, reach, swap;
      base[0] = fresh ? sx : ego_pos[0];
      base[1] = fresh ? sy : ego_pos[1];
      base[2] = fresh ? sz : ego_pos[2];
      for (int k = 0; k < 3; k++) begin
         centre = base[k] + (off_min[k] + off_max[k]) / 2;
         reach = magnitude(off_max[k] - off_min[k]) / 2 + ONE;
         if (reach > REACH_CAP) reach = REACH_CAP;
         tlo[k] = centre + jitter(reach) - longint'($urandom_range(0, 32'(reach)));
         thi[k] = tlo[k] + longint'($urandom_range(0, 32'(2 * reach)));
         if ($urandom_range(0, 19) == 0) begin
            swap = tlo[k]; tlo[k] = thi[k]; thi[k] = swap;
         end
      end
      return box_of(fresh, sx, sy, sz, tlo[0], thi[0], tlo[1], thi[1], tlo[2], thi[2]);
   endfunction

   function automatic void note_mismatch(input string what, input longint want, got);
      mismatches++;
      if (mismatches <= 10)
         $display("beat %0d: %s expected %0d got %0d", beats_seen, what, want, got);
   endfunction

   function automatic void check_field(input string what, input longint want, got);
      if (want != got) note_mismatch(what, want, got);
   endfunction

   always @(posedge clock) begin : check_beats
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            note_mismatch("unexpected beat, hit", 0, longint'(rsp_data.hit));
         end else begin
            want = pending_results.pop_front();
            check_field("hit", longint'(want.hit), longint'(rsp_data.hit));
            check_field("push_axis", longint'(want.push_axis),
                        longint'(rsp_data.push_axis));
            check_field("push_amount", longint'(want.push_amount),
                        longint'(rsp_data.push_amount));
            check_field("new_pos_x", longint'(want.new_pos_x),
                        longint'(rsp_data.new_pos_x));
            check_field("new_pos_y", longint'(want.new_pos_y),
                        longint'(rsp_data.new_pos_y));
            check_field("new_pos_z", longint'(want.new_pos_z),
                        longint'(rsp_data.new_pos_z));
         end
         beats_seen++;
      end
   end

   task automatic send_box(input req_payload_type b);
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(resolve_box(b));
      boxes_sent++;
      if (burst_left != 0) burst_left--;
   endtask

   task automatic drain_results();
      int waited;
      req_valid <= 1'b0;
      burst_left = 0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input longint value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 32'(value);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_OFF_MIN_X: off_min[0] = value;
         REG_OFF_MAX_X: off_max[0] = value;
         REG_OFF_MIN_Y: off_min[1] = value;
         REG_OFF_MAX_Y: off_max[1] = value;
         REG_OFF_MIN_Z: off_min[2] = value;
         REG_OFF_MAX_Z: off_max[2] = value;
         default: ;
      endcase
   endtask

   task automatic program_offsets(input longint lx, hx, ly, hy, lz, hz);
      drain_results();
      write_csr(REG_OFF_MIN_X, lx);
      write_csr(REG_OFF_MAX_X, hx);
      write_csr(REG_OFF_MIN_Y, ly);
      write_csr(REG_OFF_MAX_Y, hy);
      write_csr(REG_OFF_MIN_Z, lz);
      write_csr(REG_OFF_MAX_Z, hz);
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   task automatic test_default_boxes();
      gaps_on = 1'b0;
      // apart, then a three-way tie
      send_box(box_of(0, 0, 0, 0, 10*ONE, 20*ONE, 10*ONE, 20*ONE, 10*ONE, 20*ONE));
      send_box(box_of(0, 0, 0, 0, ONE/2, 3*ONE, ONE/2, 3*ONE, ONE/2, 3*ONE));
      send_box(box_of(0, 0, 0, 0, 3*ONE/4, 3*ONE, ONE/2, 3*ONE, ONE/2, 3*ONE));
      send_box(box_of(0, 0, 0, 0, 3*ONE/4, 3*ONE, ONE/2, 3*ONE, ONE/2, 3*ONE));
      send_box(box_of(1, 0, 0, 0, ONE/2, 3*ONE, -3*ONE, -3*ONE/4, ONE/2, 3*ONE));
      send_box(box_of(1, 0, 0, 0, ONE/2, 3*ONE, ONE/2, 3*ONE, 9*ONE/10, 3*ONE));
      // touching faces
      send_box(box_of(1, 0, 0, 0, ONE, 3*ONE, -3*ONE, 3*ONE, -3*ONE, 3*ONE));
      send_box(box_of(0, 0, 0, 0, -3*ONE, -ONE, -3*ONE, 3*ONE, -3*ONE, 3*ONE));
      send_box(box_of(0, 0, 0, 0, -3*ONE, 3*ONE, -3*ONE, 3*ONE, ONE, 2*ONE));
      // inverted other box
      send_box(box_of(0, 0, 0, 0, 3*ONE, -3*ONE, ONE/2, 3*ONE, ONE/2, 3*ONE));
      // position pushed past either end of the range
      send_box(box_of(1, COORD_HI, 0, 0, COORD_HI - ONE/2, COORD_HI,
                      -3*ONE, 3*ONE, -3*ONE, 3*ONE));
      send_box(box_of(1, COORD_LO, 0, 0, COORD_LO, COORD_LO + ONE/2,
                      -3*ONE, 3*ONE, -3*ONE, 3*ONE));
      send_box(box_of(1, COORD_LO, COORD_HI, 0, COORD_LO, COORD_HI,
                      COORD_LO, COORD_HI, COORD_LO, COORD_HI));
   endtask

   task automatic test_saturation();
      program_offsets(COORD_LO, COORD_HI, COORD_LO, COORD_HI, COORD_LO, COORD_HI);
      send_box(box_of(1, 0, 0, 0, COORD_LO, 0, COORD_LO, COORD_HI, COORD_LO, COORD_HI));
      send_box(box_of(1, 0, 0, 0, -2, COORD_HI, COORD_LO, COORD_HI, COORD_LO, COORD_HI));
      send_box(box_of(0, 0, 0, 0, COORD_LO, 0, COORD_LO, COORD_HI, COORD_LO, COORD_HI));
   endtask

   task automatic test_offset_settings();
      for (int s = 0; s < 6; s++) begin
         case (s)
            0: program_offsets(-ONE, ONE, -ONE, ONE, -ONE, ONE);
            1: program_offsets(COORD_LO, COORD_HI, COORD_LO, COORD_HI, COORD_LO, COORD_HI);
            2: program_offsets(0, 0, 0, 0, 0, 0);
            3: program_offsets(ONE, -ONE, 2*ONE, -ONE, ONE/2, -ONE/2);
            4: program_offsets(0, 3*ONE, -5*ONE, -ONE, COORD_HI, COORD_HI);
            default: program_offsets(longint'($signed($urandom)), longint'($signed($urandom)),
                                     longint'($signed($urandom)), longint'($signed($urandom)),
                                     longint'($signed($urandom)), longint'($signed($urandom)));
         endcase
         gaps_on = (s % 2) == 1;
         stall_on <= s >= 2;
         repeat (25) begin
            if ($urandom_range(0, 4) == 0)
               send_box(box_around(1, pick_coord(), pick_coord(), pick_coord()));
            else
               send_box(box_around(0, 0, 0, 0));
         end
      end
   endtask

   task automatic test_random_passes(input int boxes);
      longint lo [3], hi [3];
      req_payload_type junk;
      int count, passes;
      count = 0;
      passes = 0;
      while (count < boxes) begin
         if (passes % 8 == 0) begin
            for (int k = 0; k < 3; k++) begin
               if ($urandom_range(0, 4) == 0) begin
                  lo[k] = longint'($signed($urandom));
                  hi[k] = longint'($signed($urandom));
               end else begin
                  lo[k] = -longint'($urandom_range(0, 4 * 65536));
                  hi[k] = longint'($urandom_range(0, 4 * 65536));
               end
            end
            program_offsets(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
         end
         passes++;
         gaps_on = $urandom_range(0, 3) != 0;
         stall_on <= $urandom_range(0, 3) != 0;
         send_box(box_around(1, pick_coord(), pick_coord(), pick_coord()));
         count++;
         repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 9) == 0) begin
               junk = box_of(1'($urandom_range(0, 1)),
                             longint'($signed($urandom)), longint'($signed($urandom)),
                             longint'($signed($urandom)), longint'($signed($urandom)),
                             longint'($signed($urandom)), longint'($signed($urandom)),
                             longint'($signed($urandom)), longint'($signed($urandom)),
                             longint'($signed($urandom)));
               send_box(junk);
            end else begin
               send_box(box_around(0, 0, 0, 0));
            end
            count++;
         end
      end
   endtask

   initial begin
      for (int k = 0; k < 3; k++) begin
         ego_pos[k] = 0;
         off_min[k] = -ONE;
         off_max[k] = ONE;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_boxes();
      test_saturation();
      test_offset_settings();
      test_random_passes(850);

      stall_on <= 1'b0;
      drain_results();
      $display("sent %0d boxes, checked %0d result beats: %0d overlaps, %0d moves",
               boxes_sent, beats_seen, overlaps, moves);
      $display("ran %0d offset settings; %0d mismatches, %0d results never seen",
               settings_run, mismatches, pending_results.size());
      if (mismatches == 0 && pending_results.size() == 0)
         $display("PASS aabb_push_out_resolver");
      else
         $display("FAIL aabb_push_out_resolver");
      $finish;
   end

endmodule
